// ===== hdl/bptc_pkg.sv =====
// shared types and constants for the barometric compensation pipeline
package bptc_pkg;

   localparam int unsigned CAL_COUNT  = 5;
   localparam int unsigned DIV_STAGES = 32;
   localparam int unsigned OSS        = 3;

   // calibration register indexes
   typedef enum logic [2:0] {
      CAL_AC1_AC2 = 3'd0,
      CAL_AC3_AC4 = 3'd1,
      CAL_AC5_AC6 = 3'd2,
      CAL_B1_B2   = 3'd3,
      CAL_MC_MD   = 3'd4
   } cal_index_type;

   // result status codes
   typedef enum logic [1:0] {
      FAULT_NONE     = 2'd0,
      FAULT_TEMP_DIV = 2'd1,
      FAULT_PRES_DIV = 2'd2
   } fault_type;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] P_SCALE     = 32'd50000 >> OSS;
   localparam logic [31:0] K_SQ        = 32'd3038;
   localparam logic [31:0] K_LIN       = 32'hFFFF_E343; // -7357
   localparam logic [31:0] K_OFS       = 32'd3791;
   localparam logic [31:0] B4_BIAS     = 32'd32768;
   localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

endpackage

// ===== hdl/bptc_if.sv =====
// transaction channels for raw readings and compensated results
interface bptc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;
   logic [18:0] raw_pressure;
   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bptc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_decidegrees;
   logic signed [31:0] pressure_pascals;
   logic [1:0]         fault;
   modport source (output valid, output temperature_decidegrees, output pressure_pascals,
                   output fault, input ready);
   modport sink   (input valid, input temperature_decidegrees, input pressure_pascals,
                   input fault, output ready);
endinterface

// ===== hdl/bptc_div_pipe.sv =====
// unsigned 32-bit restoring divider, one quotient bit per pipeline stage
module bptc_div_pipe (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient
);

   logic [31:0] rem_w [0:bptc_pkg::DIV_STAGES];
   logic [31:0] num_w [0:bptc_pkg::DIV_STAGES];
   logic [31:0] dvs_w [0:bptc_pkg::DIV_STAGES];
   logic [31:0] quo_w [0:bptc_pkg::DIV_STAGES];

   assign rem_w[0] = '0;
   assign num_w[0] = dividend;
   assign dvs_w[0] = divisor;
   assign quo_w[0] = '0;

   for (genvar k = 0; k < bptc_pkg::DIV_STAGES; k++) begin : g_stage
      logic [32:0] trial;
      logic        ge;
      logic [31:0] rem_in, num_in, quo_in;
      logic [31:0] rem_ff, num_ff, dvs_ff, quo_ff;

      // shift in next dividend bit and try subtracting
      always_comb begin
         trial  = {rem_w[k], num_w[k][31]};
         ge     = trial >= {1'b0, dvs_w[k]};
         rem_in = ge ? 32'(trial - {1'b0, dvs_w[k]}) : trial[31:0];
         num_in = {num_w[k][30:0], 1'b0};
         quo_in = {quo_w[k][30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            num_ff <= num_in;
            dvs_ff <= dvs_w[k];
            quo_ff <= quo_in;
         end
      end

      assign rem_w[k+1] = rem_ff;
      assign num_w[k+1] = num_ff;
      assign dvs_w[k+1] = dvs_ff;
      assign quo_w[k+1] = quo_ff;
   end

   assign quotient = quo_w[bptc_pkg::DIV_STAGES];

endmodule

// ===== hdl/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation, top level.
// Each transaction carries a raw temperature and raw pressure word and yields one result
// with temperature in 0.1 degC, pressure in Pa and a fault code. The pipeline accepts one
// transaction per cycle and is built from two 32-stage radix-2 dividers (one for the temperature
// term, one for pressure) plus 14 arithmetic stages. A stalled result holds the whole pipeline.
// The user writes calibration words via the csr port only while idle; the block does not check.
module baro_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   bptc_req_if.sink    req_chan,
   bptc_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   typedef struct packed {
      logic        valid;
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic [1:0]  fault;
   } tdiv_side_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] t;
      logic        hi;
      logic [1:0]  fault;
   } pdiv_side_type;

   logic [31:0] cal_ff [0:bptc_pkg::CAL_COUNT-1];
   logic        en;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bptc_pkg::CAL_COUNT; i++) cal_ff[i] <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bptc_pkg::CAL_AC1_AC2: cal_ff[0] <= csr_write_data;
            bptc_pkg::CAL_AC3_AC4: cal_ff[1] <= csr_write_data;
            bptc_pkg::CAL_AC5_AC6: cal_ff[2] <= csr_write_data;
            bptc_pkg::CAL_B1_B2:   cal_ff[3] <= csr_write_data;
            bptc_pkg::CAL_MC_MD:   cal_ff[4] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // calibration words widened to 32 bits
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_ff[0][31]}}, cal_ff[0][31:16]};
   assign ac2 = {{16{cal_ff[0][15]}}, cal_ff[0][15:0]};
   assign ac3 = {{16{cal_ff[1][31]}}, cal_ff[1][31:16]};
   assign ac4 = {16'd0, cal_ff[1][15:0]};
   assign ac5 = {16'd0, cal_ff[2][31:16]};
   assign ac6 = {16'd0, cal_ff[2][15:0]};
   assign b1  = {{16{cal_ff[3][31]}}, cal_ff[3][31:16]};
   assign b2  = {{16{cal_ff[3][15]}}, cal_ff[3][15:0]};
   assign mc  = {{16{cal_ff[4][31]}}, cal_ff[4][31:16]};
   assign md  = {{16{cal_ff[4][15]}}, cal_ff[4][15:0]};

   // global advance: move when the output slot is free or being taken
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage 1: raw temperature product
   logic        v1_ff;
   logic [31:0] prod1_ff;
   logic [18:0] up1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_chan.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= 32'({16'd0, req_chan.raw_temperature} - ac6) * ac5;
         up1_ff   <= req_chan.raw_pressure;
      end
   end

   // stage 2: x1 and temperature divisor
   logic        v2_ff;
   logic [31:0] x1_2_ff, den2_ff;
   logic [18:0] up2_ff;
   logic [31:0] x1_2_in;
   assign x1_2_in = 32'($signed(prod1_ff) >>> 15);
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x1_2_ff <= x1_2_in;
         den2_ff <= x1_2_in + md;
         up2_ff  <= up1_ff;
      end
   end

   // stage 3: magnitudes and sign for the temperature division
   logic        v3_ff, neg3_ff;
   logic [31:0] ma3_ff, mb3_ff, x1_3_ff;
   logic [18:0] up3_ff;
   logic [1:0]  fault3_ff;
   logic [31:0] tnum;
   assign tnum = {mc[20:0], 11'd0};
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ma3_ff    <= tnum[31] ? 32'(-tnum) : tnum;
         mb3_ff    <= den2_ff[31] ? 32'(-den2_ff) : den2_ff;
         neg3_ff   <= tnum[31] ^ den2_ff[31];
         x1_3_ff   <= x1_2_ff;
         up3_ff    <= up2_ff;
         fault3_ff <= (den2_ff == '0) ? bptc_pkg::FAULT_TEMP_DIV : bptc_pkg::FAULT_NONE;
      end
   end

   // temperature division with matching sideband delay line
   logic [31:0]   tq;
   tdiv_side_type tside_ff [0:bptc_pkg::DIV_STAGES-1];
   bptc_div_pipe u_tdiv (
      .clock    (clock),
      .en       (en),
      .dividend (ma3_ff),
      .divisor  (mb3_ff),
      .quotient (tq)
   );
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bptc_pkg::DIV_STAGES; i++) tside_ff[i].valid <= 1'b0;
      end else if (en) begin
         tside_ff[0] <= '{valid: v3_ff, x1: x1_3_ff, up: up3_ff, neg: neg3_ff,
                          fault: fault3_ff};
         for (int i = 1; i < bptc_pkg::DIV_STAGES; i++) tside_ff[i] <= tside_ff[i-1];
      end
   end

   // stage 4: b5, temperature and b6
   logic        v4_ff;
   logic [31:0] t4_ff, b6_4_ff;
   logic [18:0] up4_ff;
   logic [1:0]  fault4_ff;
   logic [31:0] x2_4, b5_4;
   tdiv_side_type tlast;
   assign tlast = tside_ff[bptc_pkg::DIV_STAGES-1];
   assign x2_4  = tlast.neg ? 32'(-tq) : tq;
   assign b5_4  = tlast.x1 + x2_4;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= tlast.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         t4_ff     <= 32'($signed(32'(b5_4 + 32'd8)) >>> 4);
         b6_4_ff   <= b5_4 - bptc_pkg::B6_OFFSET;
         up4_ff    <= tlast.up;
         fault4_ff <= tlast.fault;
      end
   end

   // stage 5: products of b6
   logic        v5_ff;
   logic [31:0] pbb5_ff, pa2_5_ff, pa3_5_ff, t5_ff;
   logic [18:0] up5_ff;
   logic [1:0]  fault5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pbb5_ff   <= b6_4_ff * b6_4_ff;
         pa2_5_ff  <= ac2 * b6_4_ff;
         pa3_5_ff  <= ac3 * b6_4_ff;
         t5_ff     <= t4_ff;
         up5_ff    <= up4_ff;
         fault5_ff <= fault4_ff;
      end
   end

   // stage 6: scaled terms
   logic        v6_ff;
   logic [31:0] sq6_ff, x2a6_ff, x1c6_ff, t6_ff;
   logic [18:0] up6_ff;
   logic [1:0]  fault6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (en) v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sq6_ff    <= 32'($signed(pbb5_ff) >>> 12);
         x2a6_ff   <= 32'($signed(pa2_5_ff) >>> 11);
         x1c6_ff   <= 32'($signed(pa3_5_ff) >>> 13);
         t6_ff     <= t5_ff;
         up6_ff    <= up5_ff;
         fault6_ff <= fault5_ff;
      end
   end

   // stage 7: squared-term products
   logic        v7_ff;
   logic [31:0] pb2_7_ff, pb1_7_ff, x2a7_ff, x1c7_ff, t7_ff;
   logic [18:0] up7_ff;
   logic [1:0]  fault7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (en) v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         pb2_7_ff  <= b2 * sq6_ff;
         pb1_7_ff  <= b1 * sq6_ff;
         x2a7_ff   <= x2a6_ff;
         x1c7_ff   <= x1c6_ff;
         t7_ff     <= t6_ff;
         up7_ff    <= up6_ff;
         fault7_ff <= fault6_ff;
      end
   end

   // stage 8: b3 numerator and b4 term
   logic        v8_ff;
   logic [31:0] b3n8_ff, x3b8_ff, t8_ff;
   logic [18:0] up8_ff;
   logic [1:0]  fault8_ff;
   logic [31:0] x3_8, x3s_8;
   assign x3_8  = 32'($signed(pb2_7_ff) >>> 11) + x2a7_ff;
   assign x3s_8 = x1c7_ff + 32'($signed(pb1_7_ff) >>> 16) + 32'd2;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (en) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b3n8_ff   <= 32'(32'({ac1[29:0], 2'b00} + x3_8) << bptc_pkg::OSS) + 32'd2;
         x3b8_ff   <= 32'($signed(x3s_8) >>> 2);
         t8_ff     <= t7_ff;
         up8_ff    <= up7_ff;
         fault8_ff <= fault7_ff;
      end
   end

   // stage 9: b3 by truncating divide by four, b4 product
   logic        v9_ff;
   logic [31:0] b3_9_ff, b4p9_ff, t9_ff;
   logic [18:0] up9_ff;
   logic [1:0]  fault9_ff;
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (en) v9_ff <= v8_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b3_9_ff   <= 32'($signed(32'(b3n8_ff + (b3n8_ff[31] ? 32'd3 : 32'd0))) >>> 2);
         b4p9_ff   <= ac4 * 32'(x3b8_ff + bptc_pkg::B4_BIAS);
         t9_ff     <= t8_ff;
         up9_ff    <= up8_ff;
         fault9_ff <= fault8_ff;
      end
   end

   // stage 10: b4, b7 and pressure divisor check
   logic        v10_ff;
   logic [31:0] b4_10_ff, b7_10_ff, t10_ff;
   logic [1:0]  fault10_ff;
   logic [31:0] b4_10_in;
   assign b4_10_in = {15'd0, b4p9_ff[31:15]};
   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (en) v10_ff <= v9_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         b4_10_ff <= b4_10_in;
         b7_10_ff <= 32'({13'd0, up9_ff} - b3_9_ff) * bptc_pkg::P_SCALE;
         t10_ff   <= t9_ff;
         if (fault9_ff != bptc_pkg::FAULT_NONE) fault10_ff <= fault9_ff;
         else if (b4_10_in == '0) fault10_ff <= bptc_pkg::FAULT_PRES_DIV;
         else fault10_ff <= bptc_pkg::FAULT_NONE;
      end
   end

   // pressure division with matching sideband delay line
   logic [31:0]   pq;
   logic [31:0]   pnum;
   pdiv_side_type pside_ff [0:bptc_pkg::DIV_STAGES-1];
   assign pnum = b7_10_ff[31] ? b7_10_ff : {b7_10_ff[30:0], 1'b0};
   bptc_div_pipe u_pdiv (
      .clock    (clock),
      .en       (en),
      .dividend (pnum),
      .divisor  (b4_10_ff),
      .quotient (pq)
   );
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bptc_pkg::DIV_STAGES; i++) pside_ff[i].valid <= 1'b0;
      end else if (en) begin
         pside_ff[0] <= '{valid: v10_ff, t: t10_ff, hi: b7_10_ff[31], fault: fault10_ff};
         for (int i = 1; i < bptc_pkg::DIV_STAGES; i++) pside_ff[i] <= pside_ff[i-1];
      end
   end

   // stage 12: raw pressure
   logic        v12_ff;
   logic [31:0] p12_ff, t12_ff;
   logic [1:0]  fault12_ff;
   pdiv_side_type plast;
   assign plast = pside_ff[bptc_pkg::DIV_STAGES-1];
   always_ff @(posedge clock) begin
      if (reset) v12_ff <= 1'b0;
      else if (en) v12_ff <= plast.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         p12_ff     <= plast.hi ? {pq[30:0], 1'b0} : pq;
         t12_ff     <= plast.t;
         fault12_ff <= plast.fault;
      end
   end

   // stage 13: correction products
   logic        v13_ff;
   logic [31:0] ss13_ff, pl13_ff, p13_ff, t13_ff;
   logic [1:0]  fault13_ff;
   logic [31:0] s13;
   assign s13 = 32'($signed(p12_ff) >>> 8);
   always_ff @(posedge clock) begin
      if (reset) v13_ff <= 1'b0;
      else if (en) v13_ff <= v12_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ss13_ff    <= s13 * s13;
         pl13_ff    <= bptc_pkg::K_LIN * p12_ff;
         p13_ff     <= p12_ff;
         t13_ff     <= t12_ff;
         fault13_ff <= fault12_ff;
      end
   end

   // stage 14: scaled correction terms
   logic        v14_ff;
   logic [31:0] xa14_ff, xb14_ff, p14_ff, t14_ff;
   logic [1:0]  fault14_ff;
   always_ff @(posedge clock) begin
      if (reset) v14_ff <= 1'b0;
      else if (en) v14_ff <= v13_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         xa14_ff    <= 32'($signed(32'(ss13_ff * bptc_pkg::K_SQ)) >>> 16);
         xb14_ff    <= 32'($signed(pl13_ff) >>> 16);
         p14_ff     <= p13_ff;
         t14_ff     <= t13_ff;
         fault14_ff <= fault13_ff;
      end
   end

   // stage 15: output register
   logic        vo_ff;
   logic [31:0] to_ff, po_ff;
   logic [1:0]  fo_ff;
   logic [31:0] corr;
   assign corr = 32'($signed(32'(xa14_ff + xb14_ff + bptc_pkg::K_OFS)) >>> 4);
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (en) vo_ff <= v14_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         fo_ff <= fault14_ff;
         if (fault14_ff == bptc_pkg::FAULT_NONE) begin
            to_ff <= t14_ff;
            po_ff <= p14_ff + corr;
         end else begin
            to_ff <= '0;
            po_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid                   = vo_ff;
   assign rsp_chan.temperature_decidegrees = to_ff;
   assign rsp_chan.pressure_pascals        = po_ff;
   assign rsp_chan.fault                   = fo_ff;

`ifndef SYNTHESIS
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.fault == bptc_pkg::FAULT_NONE ||
                          rsp_chan.fault == bptc_pkg::FAULT_TEMP_DIV ||
                          rsp_chan.fault == bptc_pkg::FAULT_PRES_DIV))
      else $error("invalid fault code");
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.fault != bptc_pkg::FAULT_NONE) |->
      (rsp_chan.temperature_decidegrees == 0 && rsp_chan.pressure_pascals == 0))
      else $error("faulted result not zeroed");
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v14_ff) && $stable(p14_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

// ===== tb/baro_temp_pressure_compensation_tb.sv =====
// self-checking testbench for the barometric compensation pipeline
module baro_temp_pressure_compensation_tb;

   typedef struct {
      logic [15:0] raw_temperature;
      logic [18:0] raw_pressure;
   } reading_type;

   typedef struct {
      logic signed [31:0]  temperature_decidegrees;
      logic signed [31:0]  pressure_pascals;
      bptc_pkg::fault_type fault;
   } compensated_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   bptc_req_if req_bus ();
   bptc_rsp_if rsp_bus ();

   baro_temp_pressure_compensation uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   reading_type     pending_readings[$];
   compensated_type expected_results[$];
   logic [31:0]     cal_words[bptc_pkg::CAL_COUNT];
   int              error_count = 0;
   bit              calm = 0;
   int              send_gap = 0;
   int              recv_stall = 0;

   // clock and initial input levels
   initial begin
      clock = 0;
      reset = 1;
      csr_write_enable = 0;
      csr_index = bptc_pkg::CAL_AC1_AC2;
      csr_write_data = 0;
      req_bus.valid = 0;
      req_bus.raw_temperature = 0;
      req_bus.raw_pressure = 0;
      rsp_bus.ready = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] asr(input logic [31:0] v, input int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [31:0] sext(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

   // truncating signed division, wraps for the most negative over minus one
   function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // compensation of one reading with the current calibration words
   function automatic compensated_type compensate(input logic [15:0] ut_in,
                                                  input logic [18:0] up_in);
      compensated_type r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      logic [31:0] x1, x2, x3, den, b5, t, b6, sq, b3, b4, b7, p;
      ac1 = sext(cal_words[bptc_pkg::CAL_AC1_AC2][31:16]);
      ac2 = sext(cal_words[bptc_pkg::CAL_AC1_AC2][15:0]);
      ac3 = sext(cal_words[bptc_pkg::CAL_AC3_AC4][31:16]);
      ac4 = {16'd0, cal_words[bptc_pkg::CAL_AC3_AC4][15:0]};
      ac5 = {16'd0, cal_words[bptc_pkg::CAL_AC5_AC6][31:16]};
      ac6 = {16'd0, cal_words[bptc_pkg::CAL_AC5_AC6][15:0]};
      b1 = sext(cal_words[bptc_pkg::CAL_B1_B2][31:16]);
      b2 = sext(cal_words[bptc_pkg::CAL_B1_B2][15:0]);
      mc = sext(cal_words[bptc_pkg::CAL_MC_MD][31:16]);
      md = sext(cal_words[bptc_pkg::CAL_MC_MD][15:0]);
      ut = {16'd0, ut_in};
      up = {13'd0, up_in};
      r.temperature_decidegrees = 0;
      r.pressure_pascals = 0;
      r.fault = bptc_pkg::FAULT_NONE;
      x1 = asr((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
         r.fault = bptc_pkg::FAULT_TEMP_DIV;
         return r;
      end
      x2 = div_trunc(mc << 11, den);
      b5 = x1 + x2;
      t = asr(b5 + 32'd8, 4);
      b6 = b5 - bptc_pkg::B6_OFFSET;
      sq = asr(b6 * b6, 12);
      x1 = asr(b2 * sq, 11);
      x2 = asr(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = div_trunc(((ac1 * 32'd4 + x3) << bptc_pkg::OSS) + 32'd2, 32'd4);
      x1 = asr(ac3 * b6, 13);
      x2 = asr(b1 * sq, 16);
      x3 = asr(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + bptc_pkg::B4_BIAS)) >> 15;
      if (b4 == 0) begin
         r.fault = bptc_pkg::FAULT_PRES_DIV;
         return r;
      end
      b7 = (up - b3) * bptc_pkg::P_SCALE;
      if (b7 < bptc_pkg::SIGN_BIT) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = asr(p, 8) * asr(p, 8);
      x1 = asr(x1 * bptc_pkg::K_SQ, 16);
      x2 = asr(bptc_pkg::K_LIN * p, 16);
      p = p + asr(x1 + x2 + bptc_pkg::K_OFS, 4);
      r.temperature_decidegrees = t;
      r.pressure_pascals = p;
      return r;
   endfunction

   // driver: present queued readings, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(compensate(req_bus.raw_temperature,
                                                  req_bus.raw_pressure));
            void'(pending_readings.pop_front());
            if (!calm && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 7);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 0;
         end else if (pending_readings.size() > 0) begin
            req_bus.valid <= 1;
            req_bus.raw_temperature <= pending_readings[0].raw_temperature;
            req_bus.raw_pressure <= pending_readings[0].raw_pressure;
         end else begin
            req_bus.valid <= 0;
         end
      end
   end

   // monitor: check each result transaction against the oldest prediction
   always @(posedge clock) begin
      compensated_type want;
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result t=%0d p=%0d fault=%0d", $time,
                        rsp_bus.temperature_decidegrees, rsp_bus.pressure_pascals,
                        rsp_bus.fault);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.temperature_decidegrees !== want.temperature_decidegrees) begin
                  $display("%0t: temperature expected %0d actual %0d", $time,
                           want.temperature_decidegrees, rsp_bus.temperature_decidegrees);
                  error_count++;
               end
               if (rsp_bus.pressure_pascals !== want.pressure_pascals) begin
                  $display("%0t: pressure expected %0d actual %0d", $time,
                           want.pressure_pascals, rsp_bus.pressure_pascals);
                  error_count++;
               end
               if (rsp_bus.fault !== want.fault) begin
                  $display("%0t: fault expected %0d actual %0d", $time,
                           want.fault, rsp_bus.fault);
                  error_count++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
            if (!calm && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 7);
         end
      end
   end

   task automatic write_cal(input bptc_pkg::cal_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      cal_words[idx] = value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic write_all(input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3,
                            input logic [31:0] w4);
      write_cal(bptc_pkg::CAL_AC1_AC2, w0);
      write_cal(bptc_pkg::CAL_AC3_AC4, w1);
      write_cal(bptc_pkg::CAL_AC5_AC6, w2);
      write_cal(bptc_pkg::CAL_B1_B2, w3);
      write_cal(bptc_pkg::CAL_MC_MD, w4);
   endtask

   task automatic add_reading(input logic [15:0] ut, input logic [18:0] up);
      reading_type rd;
      rd.raw_temperature = ut;
      rd.raw_pressure = up;
      pending_readings.push_back(rd);
   endtask

   // all sent transactions answered, then a short settle
   task automatic drain;
      while (pending_readings.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_random_readings(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1) == 0)
            add_reading(16'($urandom), 19'($urandom));
         else
            add_reading(16'(27898 + $urandom_range(0, 4000) - 2000),
                        19'(190000 + $urandom_range(0, 80000) - 40000));
      end
   endtask

   // typical calibration with small random perturbation
   task automatic write_typical_jitter;
      write_all({16'd408 + 16'($urandom_range(0, 200)), 16'hFFB8 + 16'($urandom_range(0, 50))},
                {16'hC7D1 + 16'($urandom_range(0, 500)), 16'd32741 + 16'($urandom_range(0, 500))},
                {16'd32757 - 16'($urandom_range(0, 900)), 16'd23153 + 16'($urandom_range(0, 900))},
                {16'd6190 + 16'($urandom_range(0, 300)), 16'd4 + 16'($urandom_range(0, 20))},
                {16'hDDF9 + 16'($urandom_range(0, 300)), 16'd2868 + 16'($urandom_range(0, 300))});
   endtask

   // stimulus phases
   initial begin
      for (int i = 0; i < bptc_pkg::CAL_COUNT; i++) cal_words[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // reset calibration: temperature divisor is always zero
      add_reading(16'd0, 19'd0);
      add_reading(16'hFFFF, 19'h7FFFF);
      drain;

      // typical calibration, field extremes
      write_all({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
                {16'd6190, 16'd4}, {16'hDDF9, 16'd2868});
      add_reading(16'd27898, 19'd190912);
      add_reading(16'd0, 19'd0);
      add_reading(16'hFFFF, 19'h7FFFF);
      add_reading(16'd0, 19'h7FFFF);
      add_reading(16'hFFFF, 19'd0);
      add_reading(16'd23153, 19'd100000);
      add_reading(16'h8000, 19'h40000);
      add_reading(16'h7FFF, 19'h3FFFF);
      drain;

      // temperature divisor zero
      write_all({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd0, 16'd23153},
                {16'd6190, 16'd4}, {16'hDDF9, 16'd0});
      add_reading(16'd27898, 19'd190912);
      add_reading(16'hFFFF, 19'h7FFFF);
      drain;

      // pressure divisor zero
      write_all({16'd408, 16'hFFB8}, {16'hC7D1, 16'd0}, {16'd32757, 16'd23153},
                {16'd6190, 16'd4}, {16'hDDF9, 16'd2868});
      add_reading(16'd27898, 19'd190912);
      add_reading(16'd0, 19'h7FFFF);
      drain;

      // every calibration bit high, then extremes of signed halves
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_reading(16'd0, 19'd0);
      add_reading(16'hFFFF, 19'h7FFFF);
      add_reading(16'd12345, 19'd250000);
      drain;
      write_all(32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_0001, 32'h8000_7FFF, 32'h7FFF_8000);
      add_reading(16'd0, 19'd0);
      add_reading(16'hFFFF, 19'h7FFFF);
      add_reading(16'd30000, 19'd300000);
      drain;

      // random phases: calibration near typical or fully random
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 2)
            write_all($urandom, $urandom, $urandom, $urandom, $urandom);
         else
            write_typical_jitter;
         add_random_readings(110);
         drain;
      end

      // last part with no idling on either side
      calm = 1;
      write_typical_jitter;
      add_random_readings(100);
      drain;
      repeat (100) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
